FILE: hdl/rscd_pkg.sv
// ============================================================================
// rscd_pkg
// Shared types and constants for the RLE sprite decoder with screen clipping.
// ============================================================================
package rscd_pkg;

    // Screen coordinate space: both axes must stay below 2**COORD_BITS.
    localparam int COORD_BITS = 11;

    localparam int CODE_W  = 16;
    localparam int ROW_W   = 11;
    localparam int COL_W   = 17;
    localparam int RUN_W   = 16;
    localparam int PXO_W   = 11;   // width of the emitted pixel_x / pixel_y
    localparam int ORG_W   = 12;
    localparam int NROWS_W = 10;
    localparam int SCR_W   = 12;

    // Signed sums: origin plus column, origin plus row.
    localparam int X_W = COL_W + 2;
    localparam int Y_W = ORG_W + 1;

    // Unsigned compare width for the clip tests.
    localparam int CMP_W   = X_W - 1;
    localparam int COORD_LIM = 1 << COORD_BITS;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

    localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 12'd800;
    localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 12'd600;

    typedef struct packed {
        logic signed [ORG_W-1:0] origin_x;
        logic signed [ORG_W-1:0] origin_y;
        logic [NROWS_W-1:0]      sprite_rows;
        logic [SCR_W-1:0]        screen_width;
        logic [SCR_W-1:0]        screen_height;
    } t_cfg;

    // Unclipped pixel from the parser.
    typedef struct packed {
        logic                  valid;
        logic signed [X_W-1:0] x;
        logic signed [Y_W-1:0] y;
        logic [CODE_W-1:0]     colour;
    } t_pix_cand;

endpackage

FILE: hdl/rscd_in_if.sv
// ============================================================================
// rscd_in_if
// Coded word channel: one 16-bit stream word plus a sprite start flag.
// ============================================================================
interface rscd_in_if
    import rscd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_word;
    logic              sprite_start;

    modport source (output valid, output code_word, output sprite_start, input ready);
    modport sink   (input valid, input code_word, input sprite_start, output ready);
endinterface

FILE: hdl/rscd_out_if.sv
// ============================================================================
// rscd_out_if
// Pixel channel: screen coordinate and colour of one visible pixel.
// ============================================================================
interface rscd_out_if
    import rscd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PXO_W-1:0]  pixel_x;
    logic [PXO_W-1:0]  pixel_y;
    logic [CODE_W-1:0] colour;

    modport source (output valid, output pixel_x, output pixel_y, output colour,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input colour,
                    output ready);
endinterface

FILE: hdl/rscd_parse.sv
// ============================================================================
// rscd_parse
// Stream parser: tracks row, column and phase, and registers one candidate
// pixel (origin-relative sum, colour) for every pixel word.
// ============================================================================
module rscd_parse
    import rscd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    rscd_in_if.sink        i_code,
    input  logic           i_cand_ready,
    output t_pix_cand      o_cand
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_RUNS = 3'd1;
    localparam logic [2:0] PH_SKIP = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_PIX  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};

    logic [2:0]        r_phase, n_phase;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [RUN_W-1:0]  r_runs, n_runs;
    logic [RUN_W-1:0]  r_pix_left, n_pix_left;
    t_pix_cand         r_cand;

    logic              advance;
    logic              accept;
    logic [CODE_W-1:0] word;
    logic [ROW_W-1:0]  base_row;
    logic [ROW_W-1:0]  row_inc;
    logic [2:0]        row_end_phase;
    logic [COL_W:0]    skip_sum;
    logic [RUN_W-1:0]  pix_dec;
    logic [RUN_W-1:0]  runs_dec;
    logic              is_pix;

    assign advance      = !r_cand.valid || i_cand_ready;
    assign i_code.ready = advance;
    assign accept       = i_code.valid && advance;
    assign word         = i_code.code_word;

    // A start word resets the row before a zero run count ends it.
    assign base_row      = i_code.sprite_start ? '0 : r_row;
    assign row_inc       = base_row + ROW_W'(1);
    assign row_end_phase = (row_inc >= {{(ROW_W-NROWS_W){1'b0}}, i_cfg.sprite_rows}) ?
                           PH_DONE : PH_RUNS;
    assign skip_sum      = {1'b0, r_col} + {{(COL_W+1-CODE_W){1'b0}}, word};
    assign pix_dec       = r_pix_left - RUN_W'(1);
    assign runs_dec      = r_runs - RUN_W'(1);
    assign is_pix        = !i_code.sprite_start && (r_phase == PH_PIX);

    always_comb begin
        n_phase    = r_phase;
        n_row      = r_row;
        n_col      = r_col;
        n_runs     = r_runs;
        n_pix_left = r_pix_left;
        if (i_code.sprite_start) begin
            n_row      = '0;
            n_col      = '0;
            n_runs     = '0;
            n_pix_left = '0;
            if (i_cfg.sprite_rows == '0) begin
                n_phase = PH_DONE;
            end else begin
                n_runs = word;
                if (word == '0) begin
                    n_row   = row_inc;
                    n_phase = row_end_phase;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
        end else begin
            case (r_phase)
                PH_RUNS: begin
                    n_runs = word;
                    n_col  = '0;
                    if (word == '0) begin
                        n_row   = row_inc;
                        n_phase = row_end_phase;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    // saturate the column
                    n_col   = skip_sum[COL_W] ? COL_MAX : skip_sum[COL_W-1:0];
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (word == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_pix_left = word;
                        n_phase    = PH_PIX;
                    end
                end
                PH_PIX: begin
                    if (r_col != COL_MAX) begin
                        n_col = r_col + COL_W'(1);
                    end
                    n_pix_left = pix_dec;
                    if (pix_dec == '0) begin
                        n_runs = runs_dec;
                        if (runs_dec == '0) begin
                            n_row   = row_inc;
                            n_col   = '0;
                            n_phase = row_end_phase;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_row      <= '0;
            r_col      <= '0;
            r_runs     <= '0;
            r_pix_left <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_row      <= n_row;
            r_col      <= n_col;
            r_runs     <= n_runs;
            r_pix_left <= n_pix_left;
        end
    end

    // Payload: sums use the column and row before this word's update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
        end else if (advance) begin
            r_cand.valid <= accept && is_pix;
        end
        if (advance) begin
            r_cand.x      <= X_W'(i_cfg.origin_x) + $signed({2'b00, r_col});
            r_cand.y      <= Y_W'(i_cfg.origin_y) + $signed({2'b00, r_row});
            r_cand.colour <= word;
        end
    end

    assign o_cand = r_cand;

endmodule

FILE: hdl/rscd_clip.sv
// ============================================================================
// rscd_clip
// Screen clip and result register: drops candidates outside the screen or
// outside the coordinate space, and holds a visible pixel until transfer.
// ============================================================================
module rscd_clip
    import rscd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  t_pix_cand      i_cand,
    output logic           o_cand_ready,
    rscd_out_if.source     o_pix
);

    logic              r_valid;
    logic [PXO_W-1:0]  r_x;
    logic [PXO_W-1:0]  r_y;
    logic [CODE_W-1:0] r_colour;

    logic              advance;
    logic [CMP_W-1:0]  x_mag;
    logic [CMP_W-1:0]  y_mag;
    logic              x_in;
    logic              y_in;

    assign advance      = !r_valid || o_pix.ready;
    assign o_cand_ready = advance;

    assign x_mag = i_cand.x[CMP_W-1:0];
    assign y_mag = CMP_W'(i_cand.y[Y_W-2:0]);

    assign x_in = !i_cand.x[X_W-1]
               && (x_mag < CMP_W'(i_cfg.screen_width))
               && (x_mag < CMP_W'(COORD_LIM));
    assign y_in = !i_cand.y[Y_W-1]
               && (y_mag < CMP_W'(i_cfg.screen_height))
               && (y_mag < CMP_W'(COORD_LIM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_cand.valid && x_in && y_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_x      <= x_mag[PXO_W-1:0];
            r_y      <= y_mag[PXO_W-1:0];
            r_colour <= i_cand.colour;
        end
    end

    assign o_pix.valid   = r_valid;
    assign o_pix.pixel_x = r_x;
    assign o_pix.pixel_y = r_y;
    assign o_pix.colour  = r_colour;

endmodule

FILE: hdl/rle_sprite_clip_decoder.sv
// ============================================================================
// rle_sprite_clip_decoder
// Run-length sprite decoder with per-pixel screen clipping.
//
//   Channel   Dir  Handshake          Payload
//   i_code    in   valid / ready      code_word[15:0], sprite_start
//   o_pix     out  valid / ready      pixel_x[10:0], pixel_y[10:0], colour[15:0]
//   i_cfg_*   in   write enable only  index[2:0], wdata[11:0]
//
// One code word is taken every cycle unless stalled; the parser state updates
// in the cycle the word transfers. A visible pixel goes through the parser's
// candidate register and the clip's result register to o_pix. Both stages hold
// when the next one is full; ready passes back through both stages without a
// register, so i_code.ready drops in the same cycle as a stall on o_pix once
// both stages hold a pixel. Reset is synchronous and needs no clearing pass.
// ============================================================================
module rle_sprite_clip_decoder
    import rscd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rscd_in_if.sink               i_code,
    rscd_out_if.source            o_pix
);

    t_cfg      r_cfg;
    t_pix_cand cand;
    logic      cand_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.sprite_rows   <= '0;
            r_cfg.screen_width  <= SCREEN_WIDTH_RST;
            r_cfg.screen_height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_ORIGIN_X:      r_cfg.origin_x      <= i_cfg_wdata;
                REG_ORIGIN_Y:      r_cfg.origin_y      <= i_cfg_wdata;
                REG_SPRITE_ROWS:   r_cfg.sprite_rows   <= i_cfg_wdata[NROWS_W-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_wdata;
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_wdata;
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    rscd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_code       (i_code),
        .i_cand_ready (cand_ready),
        .o_cand       (cand)
    );

    rscd_clip u_clip (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cand       (cand),
        .o_cand_ready (cand_ready),
        .o_pix        (o_pix)
    );

endmodule

FILE: tb/rle_sprite_clip_decoder_test.sv
`timescale 1ns / 1ps
// ============================================================================
// rle_sprite_clip_decoder_test
// Feeds coded sprites into the decoder under random handshake gaps and
// checks every visible pixel against a cycle-free model of the row/run
// parse and the screen clip, in order, field by field.
// ============================================================================
module rle_sprite_clip_decoder_test;
    import rscd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 30;
    localparam int PHASE_WORDS     = 90;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam logic [COL_W-1:0] COL_SAT = '1;

    typedef enum logic [2:0] {
        PARSE_IDLE, PARSE_RUNS, PARSE_SKIP, PARSE_LEN, PARSE_PIX, PARSE_DONE
    } t_parse;

    typedef struct packed {
        logic [PXO_W-1:0]  x;
        logic [PXO_W-1:0]  y;
        logic [CODE_W-1:0] colour;
    } t_pixel;

    class clip_scoreboard;
        logic signed [ORG_W-1:0] org_x;
        logic signed [ORG_W-1:0] org_y;
        logic [NROWS_W-1:0]      n_rows;
        logic [SCR_W-1:0]        scr_w;
        logic [SCR_W-1:0]        scr_h;
        t_parse                  phase;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic [RUN_W-1:0]        runs_left;
        logic [RUN_W-1:0]        pix_left;
        t_pixel                  expected_pixels[$];
        int                      errors;

        function new();
            org_x     = '0;
            org_y     = '0;
            n_rows    = '0;
            scr_w     = SCREEN_WIDTH_RST;
            scr_h     = SCREEN_HEIGHT_RST;
            phase     = PARSE_IDLE;
            row       = '0;
            col       = '0;
            runs_left = '0;
            pix_left  = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ORIGIN_X:      org_x  = data;
                REG_ORIGIN_Y:      org_y  = data;
                REG_SPRITE_ROWS:   n_rows = data[NROWS_W-1:0];
                REG_SCREEN_WIDTH:  scr_w  = data;
                REG_SCREEN_HEIGHT: scr_h  = data;
                default: ;
            endcase
        endfunction

        function void next_row();
            row   = row + 1'b1;
            col   = '0;
            phase = (row >= n_rows) ? PARSE_DONE : PARSE_RUNS;
        endfunction

        function void take_run_count(logic [CODE_W-1:0] w);
            runs_left = w;
            col       = '0;
            if (w == '0) begin
                next_row();
            end else begin
                phase = PARSE_SKIP;
            end
        endfunction

        // Advance the parse by one accepted word; queue the pixel if visible.
        function void take_word(logic [CODE_W-1:0] w, logic start);
            logic [COL_W:0] col_sum;
            int             px;
            int             py;
            t_pixel         pix;
            if (start) begin
                row       = '0;
                col       = '0;
                runs_left = '0;
                pix_left  = '0;
                if (n_rows == '0) begin
                    phase = PARSE_DONE;
                end else begin
                    take_run_count(w);
                end
                return;
            end
            case (phase)
                PARSE_RUNS: take_run_count(w);
                PARSE_SKIP: begin
                    col_sum = col + w;
                    col     = (col_sum > COL_SAT) ? COL_SAT : col_sum[COL_W-1:0];
                    phase   = PARSE_LEN;
                end
                PARSE_LEN: begin
                    if (w == '0) begin
                        phase = PARSE_DONE;
                    end else begin
                        pix_left = w;
                        phase    = PARSE_PIX;
                    end
                end
                PARSE_PIX: begin
                    px = int'(org_x) + int'(col);
                    py = int'(org_y) + int'(row);
                    if (px >= 0 && py >= 0 && px < int'(scr_w) && py < int'(scr_h)
                        && px < COORD_LIM && py < COORD_LIM) begin
                        pix.x      = px[PXO_W-1:0];
                        pix.y      = py[PXO_W-1:0];
                        pix.colour = w;
                        expected_pixels.push_back(pix);
                    end
                    if (col != COL_SAT) col = col + 1'b1;
                    pix_left = pix_left - 1'b1;
                    if (pix_left == '0) begin
                        runs_left = runs_left - 1'b1;
                        if (runs_left == '0) begin
                            next_row();
                        end else begin
                            phase = PARSE_SKIP;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function bit count_error();
            errors++;
            return errors <= MAX_REPORTS;
        endfunction

        function void check_pixel(logic [PXO_W-1:0] x, logic [PXO_W-1:0] y,
                                  logic [CODE_W-1:0] c);
            t_pixel exp_pix;
            if (expected_pixels.size() == 0) begin
                if (count_error())
                    $display("%0t: unexpected pixel x=%0d y=%0d colour=%h",
                             $time, x, y, c);
                return;
            end
            exp_pix = expected_pixels.pop_front();
            if (x !== exp_pix.x && count_error())
                $display("%0t: pixel_x mismatch: expected %0d, got %0d",
                         $time, exp_pix.x, x);
            if (y !== exp_pix.y && count_error())
                $display("%0t: pixel_y mismatch: expected %0d, got %0d",
                         $time, exp_pix.y, y);
            if (c !== exp_pix.colour && count_error())
                $display("%0t: colour mismatch: expected %h, got %h",
                         $time, exp_pix.colour, c);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rscd_in_if  code_if ();
    rscd_out_if pix_if ();

    clip_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_reqs;
    int quiet_cycles;
    int phase_words;

    rle_sprite_clip_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_code      (code_if),
        .o_pix       (pix_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pixel sink: random stalls, plus a long hold-off when requested.
    initial begin
        int hold_off_left;
        int hold_off_seen;
        hold_off_left = 0;
        hold_off_seen = 0;
        pix_if.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_seen != hold_off_reqs) begin
                hold_off_seen = hold_off_reqs;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                pix_if.ready <= 1'b0;
            end else begin
                pix_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && pix_if.valid === 1'b1 && pix_if.ready === 1'b1)
            sb.check_pixel(pix_if.pixel_x, pix_if.pixel_y, pix_if.colour);
    end

    always @(posedge clk) begin
        if ((code_if.valid && code_if.ready) || (pix_if.valid && pix_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Enter and leave at a falling edge; valid stays high for the next word.
    task automatic send_word(input logic [CODE_W-1:0] w, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            code_if.valid <= 1'b0;
            @(negedge clk);
        end
        code_if.valid        <= 1'b1;
        code_if.code_word    <= w;
        code_if.sprite_start <= start;
        @(posedge clk);
        while (code_if.ready !== 1'b1) @(posedge clk);
        sb.take_word(w, start);
        phase_words++;
        @(negedge clk);
    endtask

    // Drop valid, drain every expected pixel, then let the pipeline empty.
    task automatic settle();
        code_if.valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] ox, input logic [CFG_DATA_W-1:0] oy,
                             input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_SPRITE_ROWS, rows);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_origin();
        if ($urandom_range(3) == 0) return CFG_DATA_W'($urandom_range(4095));
        return CFG_DATA_W'(int'($urandom_range(80)) - 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_extent();
        case ($urandom_range(15))
            0:          return CFG_DATA_W'(0);
            1, 2:       return CFG_DATA_W'(2048);
            3, 4, 5, 6: return CFG_DATA_W'($urandom_range(1, 2048));
            default:    return CFG_DATA_W'($urandom_range(1, 100));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_rows();
        case ($urandom_range(15))
            0:       return CFG_DATA_W'(0);
            1:       return CFG_DATA_W'(1023);
            default: return CFG_DATA_W'($urandom_range(1, 5));
        endcase
    endfunction

    // One well-formed sprite, sometimes cut short so the next start lands mid-parse.
    task automatic send_random_sprite();
        int                rows;
        int                runs;
        int                len;
        int                r;
        int                k;
        int                p;
        bit                wide;
        bit                first;
        logic [CODE_W-1:0] skip;
        first = 1'b1;
        wide  = ($urandom_range(9) == 0);
        if (sb.n_rows == '0)
            rows = 1;
        else if (sb.n_rows > 6)
            rows = $urandom_range(1, 6);
        else
            rows = sb.n_rows + ($urandom_range(7) == 0);  // extra row must be ignored
        for (r = 0; r < rows; r++) begin
            runs = wide ? $urandom_range(2, 3) : $urandom_range(0, 3);
            send_word(CODE_W'(runs), first);
            first = 1'b0;
            for (k = 0; k < runs; k++) begin
                // wide sprites push the column into saturation
                if (wide)
                    skip = 16'hFFFF;
                else if ($urandom_range(15) == 0)
                    skip = CODE_W'($urandom_range(65535));
                else
                    skip = CODE_W'($urandom_range(30));
                send_word(skip, 1'b0);
                if ($urandom_range(59) == 0) return;
                len = ($urandom_range(24) == 0) ? 0 : $urandom_range(1, 6);
                send_word(CODE_W'(len), 1'b0);
                if (len == 0) return;
                for (p = 0; p < len; p++) begin
                    if ($urandom_range(59) == 0) return;
                    send_word(CODE_W'($urandom_range(65535)), 1'b0);
                end
            end
        end
    endtask

    initial begin
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_index            <= '0;
        cfg_wdata            <= '0;
        code_if.valid        <= 1'b0;
        code_if.code_word    <= '0;
        code_if.sprite_start <= 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 71;
        hold_off_reqs = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: no rows, so a start finishes the sprite at once.
        send_word(16'h1234, 1'b0);
        send_word(16'h0002, 1'b1);
        settle();
        write_reg(REG_SPRITE_ROWS, 12'd3);

        // Reset screen size: clip at column 800, empty row, then a long row 2.
        send_word(16'd1, 1'b1);
        send_word(16'd798, 1'b0);
        send_word(16'd3, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hA5A5, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd2, 1'b0);
        send_word(16'h1357, 1'b0);
        settle();
        // Lower the row count mid-sprite: finishing row 2 ends the sprite.
        write_reg(REG_SPRITE_ROWS, 12'd1);
        send_word(16'h2468, 1'b0);
        send_word(16'h0101, 1'b0);
        settle();

        // Origin extremes: left of screen, bottom row, then row past the screen.
        configure(12'h800, 12'h7FF, 12'd1023, 12'd2048, 12'd2048);
        send_word(16'd1, 1'b1);
        send_word(16'd2047, 1'b0);
        send_word(16'd2, 1'b0);
        send_word(16'h8001, 1'b0);
        send_word(16'h7FFE, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'd2048, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'hC3C3, 1'b0);
        send_word(16'd1, 1'b1);
        send_word(16'd0, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'h4242, 1'b0);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 8;
                recv_idle_pct = 71;
            end else if (ph < 6) begin
                send_idle_pct = 71;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 0) begin
                // origin at zero and the largest screen, and hold the sink so the input backs up
                configure(12'd0, 12'd0, 12'd4, 12'd2048, 12'd2048);
                hold_off_reqs++;
            end else begin
                configure(random_origin(), random_origin(), random_rows(),
                          random_extent(), random_extent());
            end
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                send_random_sprite();
                if ($urandom_range(5) == 0)
                    repeat ($urandom_range(1, 3))
                        send_word(CODE_W'($urandom_range(65535)), 1'b0);
            end
            settle();
        end

        if (sb.errors == 0 && sb.expected_pixels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
